// File: src/plsm_pkg.sv
package plsm_pkg;

    localparam int MAX_BREAKS_DEF = 63;
    localparam int Q_W            = 32;
    localparam int WIDE_W         = 50;
    localparam int TDATA_W        = 96;

    typedef logic signed [Q_W-1:0]    q16_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    typedef struct packed {
        logic valid;
        q16_t pos;
        q16_t delta;
    } brk_t;

    localparam brk_t BRK_EMPTY = '0;

    typedef enum logic [1:0] {
        CH_HOLD,
        CH_INSERT,
        CH_POP
    } chain_op_t;

    typedef struct packed {
        chain_op_t op;
        q16_t      x;
        q16_t      delta;
    } chain_cmd_t;

    localparam wide_t Q_MAX = wide_t'(64'sd2147483647);
    localparam wide_t Q_MIN = wide_t'(-64'sd2147483648);

    function automatic wide_t widen(input q16_t v);
        widen = {{(WIDE_W-Q_W){v[Q_W-1]}}, v};
    endfunction

    function automatic q16_t sat32(input wide_t v);
        if (v > Q_MAX)
        begin
            sat32 = Q_MAX[Q_W-1:0];
        end
        else if (v < Q_MIN)
        begin
            sat32 = Q_MIN[Q_W-1:0];
        end
        else
        begin
            sat32 = v[Q_W-1:0];
        end
    endfunction

endpackage

// File: src/plsm_cell.sv
module plsm_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  plsm_pkg::chain_cmd_t cmd,
    input  logic              shift_en,
    input  plsm_pkg::brk_t    left,
    input  logic              left_gt,
    input  plsm_pkg::brk_t    right,
    output plsm_pkg::brk_t    entry,
    output logic              gt,
    output logic              eq
);
    import plsm_pkg::*;

    brk_t entry_reg;
    brk_t entry_next;

    assign entry = entry_reg;
    assign gt    = !entry_reg.valid || (entry_reg.pos > cmd.x);
    assign eq    = entry_reg.valid && (entry_reg.pos == cmd.x);

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.op)
            CH_INSERT:
            begin
                if (eq)
                begin
                    entry_next.delta = sat32(widen(entry_reg.delta) + widen(cmd.delta));
                end
                else if (shift_en && gt)
                begin
                    if (left_gt)
                    begin
                        entry_next = left;
                    end
                    else
                    begin
                        entry_next.valid = 1'b1;
                        entry_next.pos   = cmd.x;
                        entry_next.delta = cmd.delta;
                    end
                end
            end
            CH_POP:
            begin
                entry_next = right;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= BRK_EMPTY;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

// File: src/plsm_emit.sv
module plsm_emit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  plsm_pkg::q16_t               start_value,
    input  plsm_pkg::q16_t               start_slope,
    input  plsm_pkg::brk_t               head,
    input  logic                         next_valid,
    output logic                         pop,
    output logic                         busy,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // sum_x, sum_y, sum_slope
    output logic [plsm_pkg::TDATA_W-1:0] m_axis_tdata,
    // last_point
    output logic                         m_axis_tlast
);
    import plsm_pkg::*;

    typedef enum logic [2:0] {
        E_IDLE,
        E_HEAD,
        E_DIFF,
        E_MUL,
        E_ACC
    } emit_state_t;

    emit_state_t              state_reg;
    q16_t                     px_reg;
    q16_t                     py_reg;
    q16_t                     ps_reg;
    q16_t                     bx_reg;
    q16_t                     dl_reg;
    logic                     last_reg;
    logic signed [Q_W:0]      dx_reg;
    logic signed [2*Q_W:0]    prod_reg;
    logic                     tvalid_reg;
    q16_t                     out_x_reg;
    q16_t                     out_y_reg;
    q16_t                     out_s_reg;
    logic                     out_last_reg;

    logic                     out_free;
    logic                     out_load;
    wide_t                    term;
    q16_t                     py_acc;
    q16_t                     ps_acc;

    assign out_free = !tvalid_reg || m_axis_tready;
    assign out_load = out_free && ((state_reg == E_HEAD) || (state_reg == E_ACC));
    assign term     = {prod_reg[2*Q_W], prod_reg[2*Q_W:16]};
    assign py_acc   = sat32(widen(py_reg) + term);
    assign ps_acc   = sat32(widen(ps_reg) + widen(dl_reg));

    assign pop           = (state_reg == E_DIFF);
    assign busy          = (state_reg != E_IDLE);
    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tdata  = {out_s_reg, out_y_reg, out_x_reg};
    assign m_axis_tlast  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= E_IDLE;
            tvalid_reg   <= 1'b0;
            px_reg       <= '0;
            py_reg       <= '0;
            ps_reg       <= '0;
            bx_reg       <= '0;
            dl_reg       <= '0;
            last_reg     <= 1'b0;
            dx_reg       <= '0;
            prod_reg     <= '0;
            out_x_reg    <= '0;
            out_y_reg    <= '0;
            out_s_reg    <= '0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                tvalid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                tvalid_reg <= 1'b0;
            end
            case (state_reg)
                E_IDLE:
                begin
                    if (start)
                    begin
                        px_reg    <= '0;
                        py_reg    <= start_value;
                        ps_reg    <= start_slope;
                        state_reg <= E_HEAD;
                    end
                end
                E_HEAD:
                begin
                    if (out_free)
                    begin
                        out_x_reg    <= '0;
                        out_y_reg    <= py_reg;
                        out_s_reg    <= ps_reg;
                        out_last_reg <= !head.valid;
                        state_reg    <= head.valid ? E_DIFF : E_IDLE;
                    end
                end
                E_DIFF:
                begin
                    dx_reg    <= {head.pos[Q_W-1], head.pos} - {px_reg[Q_W-1], px_reg};
                    bx_reg    <= head.pos;
                    dl_reg    <= head.delta;
                    last_reg  <= !next_valid;
                    state_reg <= E_MUL;
                end
                E_MUL:
                begin
                    prod_reg  <= dx_reg * ps_reg;
                    state_reg <= E_ACC;
                end
                E_ACC:
                begin
                    if (out_free)
                    begin
                        py_reg       <= py_acc;
                        ps_reg       <= ps_acc;
                        px_reg       <= bx_reg;
                        out_x_reg    <= bx_reg;
                        out_y_reg    <= py_acc;
                        out_s_reg    <= ps_acc;
                        out_last_reg <= last_reg;
                        state_reg    <= last_reg ? E_IDLE : E_DIFF;
                    end
                end
                default:
                begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

endmodule

// File: src/piecewise_linear_sum_merge.sv
// Sums piecewise-linear functions given as breakpoint requests on s_axis and streams the summed
// function on m_axis as points (x, y, slope). Loading takes one request per cycle while
// s_axis_tready is high: each request is registered once and then, unless it is the first point
// of a function, applied to a row of MAX_BREAKS compare-and-shift cells that keep the breakpoints
// sorted and merge equal positions. A request with tlast is registered and then starts emission;
// s_axis_tready stays low until the last point has been handed to the output register. Emission
// gives the start point, then works through each breakpoint as difference, 33x32 multiply and
// saturating accumulate, and stalls while the output register is full and m_axis_tready is low.
// Breakpoints beyond MAX_BREAKS with a new position are dropped. No clearing pass follows reset.
module piecewise_linear_sum_merge #(
    parameter int MAX_BREAKS = plsm_pkg::MAX_BREAKS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // point_x, point_y, point_slope
    input  logic [plsm_pkg::TDATA_W-1:0] s_axis_tdata,
    // first_of_function
    input  logic                         s_axis_tuser,
    // last_item
    input  logic                         s_axis_tlast,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // sum_x, sum_y, sum_slope
    output logic [plsm_pkg::TDATA_W-1:0] m_axis_tdata,
    // last_point
    output logic                         m_axis_tlast
);
    import plsm_pkg::*;

    logic       accept;
    q16_t       in_x;
    q16_t       in_y;
    q16_t       in_s;

    logic       stage_valid_reg;
    logic       stage_first_reg;
    logic       stage_last_reg;
    q16_t       stage_x_reg;
    q16_t       stage_y_reg;
    q16_t       stage_s_reg;
    q16_t       stage_delta_reg;
    q16_t       prev_slope_reg;
    q16_t       prev_slope_next;
    q16_t       start_value_reg;
    q16_t       start_value_next;
    q16_t       start_slope_reg;
    q16_t       start_slope_next;
    q16_t       applied_value;
    q16_t       applied_slope;

    chain_cmd_t cmd;
    logic       shift_en;
    brk_t       ent [MAX_BREAKS];
    logic [MAX_BREAKS-1:0] gt_vec;
    logic [MAX_BREAKS-1:0] eq_vec;
    logic       next_valid;
    logic       emit_start;
    logic       emit_pop;
    logic       emit_busy;

    assign in_x   = s_axis_tdata[Q_W-1:0];
    assign in_y   = s_axis_tdata[2*Q_W-1:Q_W];
    assign in_s   = s_axis_tdata[3*Q_W-1:2*Q_W];
    assign accept = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = !emit_busy && !(stage_valid_reg && stage_last_reg);

    // fold start values of a first point
    always_comb
    begin
        applied_value = start_value_reg;
        applied_slope = start_slope_reg;
        if (stage_valid_reg && stage_first_reg)
        begin
            applied_value = sat32(widen(start_value_reg) + widen(stage_y_reg));
            applied_slope = sat32(widen(start_slope_reg) + widen(stage_s_reg));
        end
    end

    assign emit_start = stage_valid_reg && stage_last_reg;

    always_comb
    begin
        start_value_next = emit_start ? '0 : applied_value;
        start_slope_next = emit_start ? '0 : applied_slope;
        prev_slope_next  = prev_slope_reg;
        if (accept)
        begin
            prev_slope_next = s_axis_tlast ? '0 : in_s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            stage_first_reg <= 1'b0;
            stage_last_reg  <= 1'b0;
            prev_slope_reg  <= '0;
            start_value_reg <= '0;
            start_slope_reg <= '0;
        end
        else
        begin
            stage_valid_reg <= accept;
            if (accept)
            begin
                stage_first_reg <= s_axis_tuser;
                stage_last_reg  <= s_axis_tlast;
            end
            prev_slope_reg  <= prev_slope_next;
            start_value_reg <= start_value_next;
            start_slope_reg <= start_slope_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_x_reg     <= in_x;
            stage_y_reg     <= in_y;
            stage_s_reg     <= in_s;
            stage_delta_reg <= sat32(widen(in_s) - widen(prev_slope_reg));
        end
    end

    assign shift_en = !(|eq_vec) && !ent[MAX_BREAKS-1].valid;

    always_comb
    begin
        cmd.x     = stage_x_reg;
        cmd.delta = stage_delta_reg;
        if (emit_pop)
        begin
            cmd.op = CH_POP;
        end
        else if (stage_valid_reg && !stage_first_reg)
        begin
            cmd.op = CH_INSERT;
        end
        else
        begin
            cmd.op = CH_HOLD;
        end
    end

    for (genvar i = 0; i < MAX_BREAKS; i++)
    begin : g_cell
        brk_t left;
        logic left_gt;
        brk_t right;

        if (i == 0)
        begin : g_first
            assign left    = BRK_EMPTY;
            assign left_gt = 1'b0;
        end
        else
        begin : g_mid
            assign left    = ent[i-1];
            assign left_gt = gt_vec[i-1];
        end

        if (i == MAX_BREAKS - 1)
        begin : g_end
            assign right = BRK_EMPTY;
        end
        else
        begin : g_inner
            assign right = ent[i+1];
        end

        plsm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .shift_en (shift_en),
            .left     (left),
            .left_gt  (left_gt),
            .right    (right),
            .entry    (ent[i]),
            .gt       (gt_vec[i]),
            .eq       (eq_vec[i])
        );
    end

    if (MAX_BREAKS > 1)
    begin : g_next_many
        assign next_valid = ent[1].valid;
    end
    else
    begin : g_next_one
        assign next_valid = 1'b0;
    end

    plsm_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (emit_start),
        .start_value   (applied_value),
        .start_slope   (applied_slope),
        .head          (ent[0]),
        .next_valid    (next_valid),
        .pop           (emit_pop),
        .busy          (emit_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_axis_tlast |=> !s_axis_tready)
        else $error("request accepted right after a last request");

    a_pop_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        emit_pop |-> ent[0].valid)
        else $error("pop from an empty breakpoint row");

    a_no_insert_emit: assert property (@(posedge clk) disable iff (!rst_n)
        emit_busy |-> !stage_valid_reg)
        else $error("breakpoint applied during emission");

    a_head_first: assert property (@(posedge clk) disable iff (!rst_n)
        next_valid |-> ent[0].valid)
        else $error("breakpoint row not filled from the head");

endmodule
